FILE: rtl/counter_machine_execute_unit_top_macros.svh
// assertion macros for the counter machine execute unit
// no dependencies; included by cme_ctrl, the only module that carries assertions
`ifndef COUNTER_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH
`define COUNTER_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CME_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cme assertion failed");

// next-cycle implication, disabled during reset
`define CME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cme assertion failed");

`endif

FILE: rtl/cme_pkg.sv
// shared types and constants for the counter machine execute unit
// no dependencies; used by cme_mem, cme_ctrl and the top level
package cme_pkg;

  localparam int WORD_BITS  = 32;
  localparam int MEM_WORDS  = 256;
  localparam int ADDR_BITS  = $clog2(MEM_WORDS);
  localparam int MAX_DEREFS = 3;
  localparam int DEREF_BITS = 2;
  localparam int PTR_BITS   = 32;
  localparam int LEN_BITS   = 16;
  localparam int MADDR_BITS = 8;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [PTR_BITS-1:0]   ptr_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [DEREF_BITS-1:0] deref_t;

  typedef enum logic [1:0] {
    ACT_EXEC    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_INC = 3'd0,
    OP_DEC = 3'd1,
    OP_JMP = 3'd2,
    OP_TST = 3'd3,
    OP_HLT = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

  // one access to the counter memory
  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

endpackage

FILE: rtl/counter_machine_execute_unit_top.sv
// Counter machine execute unit. A transaction is accepted when start is high and busy is
// low; busy stays high until its result has been shown. The result appears for exactly one
// cycle with done high and cannot be held off, so the receiver must take it then. Restart
// and an ignored execute go from the accepting edge straight to the done state; a write
// passes through the write state first. A read or an execute passes through one issue and
// one wait state for every indirection and for the counter read, and inc or dec adds a
// write-back state. This sequence is set by the single-port counter memory.
// Counters clear on reset through per-entry valid flags, so no clearing pass is needed.
// depends on cme_pkg, cme_mem and cme_ctrl
module counter_machine_execute_unit_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_we,
  input  cme_pkg::len_t                  cfg_wdata,
  input  logic [1:0]                     action,
  input  logic [2:0]                     opcode,
  input  cme_pkg::deref_t                deref_count,
  input  cme_pkg::word_t                 operand,
  input  logic [cme_pkg::MADDR_BITS-1:0] mem_address,
  input  cme_pkg::word_t                 mem_value,
  output cme_pkg::ptr_t                  next_pointer,
  output logic                           halted,
  output logic                           finished,
  output cme_pkg::word_t                 halt_value,
  output cme_pkg::word_t                 read_data,
  output logic                           range_error
);

  cme_pkg::mem_req_t mem_req;
  cme_pkg::word_t    mem_rdata;

  cme_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .action       (action),
    .opcode       (opcode),
    .deref_count  (deref_count),
    .operand      (operand),
    .mem_address  (mem_address),
    .mem_value    (mem_value),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .next_pointer (next_pointer),
    .halted       (halted),
    .finished     (finished),
    .halt_value   (halt_value),
    .read_data    (read_data),
    .range_error  (range_error)
  );

  cme_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

FILE: rtl/cme_mem.sv
// single-port counter memory with registered read data
// entries never written since reset read as zero (per-entry valid flops)
// depends on cme_pkg
module cme_mem (
  input  logic              clk,
  input  logic              rst,
  input  cme_pkg::mem_req_t req,
  output cme_pkg::word_t    rdata
);

  cme_pkg::word_t               mem [cme_pkg::MEM_WORDS];
  logic [cme_pkg::MEM_WORDS-1:0] valid;
  cme_pkg::word_t               rd_word;
  logic                         rd_valid;

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rd_word <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.en && req.we) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.en && !req.we) begin
        rd_valid <= valid[req.addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

FILE: rtl/cme_ctrl.sv
// sequencer: dereference chain, read-modify-write of a counter, direct reads and writes, pointer and halt state
// depends on cme_pkg and counter_machine_execute_unit_top_macros.svh
`include "counter_machine_execute_unit_top_macros.svh"

module cme_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  output logic                       done,
  input  logic                       cfg_we,
  input  cme_pkg::len_t              cfg_wdata,
  input  logic [1:0]                 action,
  input  logic [2:0]                 opcode,
  input  cme_pkg::deref_t            deref_count,
  input  cme_pkg::word_t             operand,
  input  logic [cme_pkg::MADDR_BITS-1:0] mem_address,
  input  cme_pkg::word_t             mem_value,
  output cme_pkg::mem_req_t          mem_req,
  input  cme_pkg::word_t             mem_rdata,
  output cme_pkg::ptr_t              next_pointer,
  output logic                       halted,
  output logic                       finished,
  output cme_pkg::word_t             halt_value,
  output cme_pkg::word_t             read_data,
  output logic                       range_error
);

  cme_pkg::state_t state, state_next;
  logic [1:0]      act_q, act_next;
  logic [2:0]      op_q, op_next;
  cme_pkg::deref_t n_q, n_next;
  cme_pkg::word_t  arg_q, arg_next;
  cme_pkg::word_t  mval_q, mval_next;
  logic            oob_q, oob_next;
  cme_pkg::ptr_t   pointer, pointer_next;
  logic            stopped, stopped_next;
  cme_pkg::word_t  halt_val, halt_val_next;
  cme_pkg::word_t  rdata_q, rdata_next;
  logic            err_q, err_next;
  cme_pkg::len_t   prog_len;

  logic            arg_in_range;
  logic            runnable;
  cme_pkg::word_t  word_val;
  cme_pkg::deref_t n_sat;

  assign arg_in_range = arg_q < cme_pkg::WORD_BITS'(cme_pkg::MEM_WORDS);
  assign runnable     = !stopped && (pointer < cme_pkg::PTR_BITS'(prog_len));
  // out-of-range reads never touch the memory and yield zero
  assign word_val     = oob_q ? '0 : mem_rdata;
  assign n_sat = (deref_count > cme_pkg::DEREF_BITS'(cme_pkg::MAX_DEREFS))
               ? cme_pkg::DEREF_BITS'(cme_pkg::MAX_DEREFS) : deref_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cme_pkg::S_IDLE;
      pointer  <= '0;
      stopped  <= 1'b0;
      halt_val <= '0;
      prog_len <= '0;
      rdata_q  <= '0;
      err_q    <= 1'b0;
    end else begin
      state    <= state_next;
      pointer  <= pointer_next;
      stopped  <= stopped_next;
      halt_val <= halt_val_next;
      rdata_q  <= rdata_next;
      err_q    <= err_next;
      if (cfg_we) begin
        prog_len <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_q  <= act_next;
    op_q   <= op_next;
    n_q    <= n_next;
    arg_q  <= arg_next;
    mval_q <= mval_next;
    oob_q  <= oob_next;
  end

  always_comb begin
    state_next    = state;
    act_next      = act_q;
    op_next       = op_q;
    n_next        = n_q;
    arg_next      = arg_q;
    mval_next     = mval_q;
    oob_next      = oob_q;
    pointer_next  = pointer;
    stopped_next  = stopped;
    halt_val_next = halt_val;
    rdata_next    = rdata_q;
    err_next      = err_q;
    mem_req       = '0;
    done          = 1'b0;
    busy          = (state != cme_pkg::S_IDLE);

    unique case (state)
      cme_pkg::S_IDLE: begin
        if (start) begin
          act_next   = action;
          op_next    = opcode;
          rdata_next = '0;
          err_next   = 1'b0;
          unique case (action)
            cme_pkg::ACT_EXEC: begin
              // a finished machine ignores execute transactions
              if (runnable) begin
                arg_next   = operand;
                n_next     = n_sat;
                state_next = cme_pkg::S_ISSUE;
              end else begin
                state_next = cme_pkg::S_DONE;
              end
            end
            cme_pkg::ACT_WRITE: begin
              arg_next   = cme_pkg::WORD_BITS'(mem_address);
              mval_next  = mem_value;
              state_next = cme_pkg::S_WRITE;
            end
            cme_pkg::ACT_READ: begin
              arg_next   = cme_pkg::WORD_BITS'(mem_address);
              n_next     = '0;
              state_next = cme_pkg::S_ISSUE;
            end
            cme_pkg::ACT_RESTART: begin
              pointer_next  = '0;
              stopped_next  = 1'b0;
              halt_val_next = '0;
              state_next    = cme_pkg::S_DONE;
            end
          endcase
        end
      end

      cme_pkg::S_ISSUE: begin
        mem_req.en   = arg_in_range;
        mem_req.addr = arg_q[cme_pkg::ADDR_BITS-1:0];
        oob_next     = !arg_in_range;
        state_next   = cme_pkg::S_WAIT;
      end

      cme_pkg::S_WAIT: begin
        if (n_q != '0) begin
          // one more indirection
          arg_next   = word_val;
          n_next     = n_q - 1'b1;
          state_next = cme_pkg::S_ISSUE;
        end else if (act_q == cme_pkg::ACT_READ) begin
          rdata_next = word_val;
          state_next = cme_pkg::S_DONE;
        end else begin
          pointer_next = pointer + 1'b1;
          state_next   = cme_pkg::S_DONE;
          unique case (op_q)
            cme_pkg::OP_INC: begin
              mval_next  = word_val + 1'b1;
              state_next = cme_pkg::S_WRITE;
            end
            cme_pkg::OP_DEC: begin
              mval_next  = word_val - 1'b1;
              state_next = cme_pkg::S_WRITE;
            end
            cme_pkg::OP_JMP: begin
              pointer_next = cme_pkg::PTR_BITS'(arg_q);
            end
            cme_pkg::OP_TST: begin
              if (word_val == '0) begin
                pointer_next = pointer + 2'd2;
              end
            end
            cme_pkg::OP_HLT: begin
              stopped_next  = 1'b1;
              halt_val_next = arg_q;
            end
            default: begin
              // undefined opcodes only advance the pointer
            end
          endcase
        end
      end

      cme_pkg::S_WRITE: begin
        if (arg_in_range) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = arg_q[cme_pkg::ADDR_BITS-1:0];
          mem_req.wdata = mval_q;
        end else begin
          err_next = 1'b1;
        end
        state_next = cme_pkg::S_DONE;
      end

      cme_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = cme_pkg::S_IDLE;
      end

      default: begin
        state_next = cme_pkg::S_IDLE;
      end
    endcase
  end

  assign next_pointer = pointer;
  assign halted       = stopped;
  assign finished     = stopped || (pointer >= cme_pkg::PTR_BITS'(prog_len));
  assign halt_value   = halt_val;
  assign read_data    = rdata_q;
  assign range_error  = err_q;

  `CME_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CME_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  `CME_ASSERT_NOW(a_write_state, clk, rst, mem_req.we, state == cme_pkg::S_WRITE && arg_in_range)
  `CME_ASSERT_NOW(a_halt_cause, clk, rst, $rose(stopped), $past(op_q) == cme_pkg::OP_HLT)
  `CME_ASSERT_NEXT(a_deref_loop, clk, rst, state == cme_pkg::S_WAIT && n_q != '0,
                   state == cme_pkg::S_ISSUE)

endmodule
